// ===== rtl/srr_pkg.sv =====
// srr_pkg: shared constants, result codes and the slot store command struct
// for the selective-repeat receiver. No dependencies.
`default_nettype none

package srr_pkg;

   localparam int WINDOW_MAX   = 32;
   localparam int IDX_BITS     = $clog2(WINDOW_MAX);
   localparam int SEQ_BITS     = 32;
   localparam int PAYLOAD_BITS = 64;
   localparam int WIN_BITS     = 6;

   localparam logic [SEQ_BITS-1:0] SEQ_START    = SEQ_BITS'(1);
   localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(8);

   // result kind codes
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef struct packed {
      logic                    wr_en;
      logic [IDX_BITS-1:0]     wr_idx;
      logic [PAYLOAD_BITS-1:0] wr_data;
      logic                    clr_en;
      logic [IDX_BITS-1:0]     clr_idx;
      logic [IDX_BITS-1:0]     rd_idx;
      logic [IDX_BITS-1:0]     chk_idx;
   } srr_store_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/srr_if.sv =====
// srr_req_if / srr_rsp_if: valid-ready channels for arriving packets and
// for acknowledgement / delivery results. Depends on srr_pkg.
`default_nettype none

interface srr_req_if;
   import srr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    corrupted;
   logic [SEQ_BITS-1:0]     seq_num;
   logic [PAYLOAD_BITS-1:0] payload_word;

   modport source (output valid, output corrupted, output seq_num, output payload_word,
                   input ready);
   modport sink   (input valid, input corrupted, input seq_num, input payload_word,
                   output ready);
endinterface

interface srr_rsp_if;
   import srr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SEQ_BITS-1:0]     ack_num;
   logic [PAYLOAD_BITS-1:0] delivered_payload;
   logic                    last;

   modport source (output valid, output kind, output ack_num, output delivered_payload,
                   output last, input ready);
   modport sink   (input valid, input kind, input ack_num, input delivered_payload,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/selective_repeat_receiver_top.sv =====
// selective_repeat_receiver_top: selective-repeat ARQ receiver.
// The acknowledgement is registered and appears in the cycle after the packet beat.
// A corrupted, out-of-window or stored packet leaves the receiver idle; an in-order
// packet is delivered and the stored slots after it are drained, one delivery per
// cycle while output is free, paced by the output register and the registered read.
// Reset: expected number 1, window 8, slot valid map cleared.
`default_nettype none

module selective_repeat_receiver_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [srr_pkg::WIN_BITS-1:0] csr_wdata,
   srr_req_if.sink                           req_chan,
   srr_rsp_if.source                         rsp_chan
);
   import srr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DELIV,
      ST_DRAIN
   } state_type;

   state_type               state_ff;
   logic [SEQ_BITS-1:0]     exp_ff;
   logic [WIN_BITS-1:0]     win_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [SEQ_BITS-1:0]     rsp_ack_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic                    rsp_last_ff;

   logic [WIN_BITS-1:0]     win_eff;
   logic [SEQ_BITS-1:0]     offset;
   logic [SEQ_BITS-1:0]     exp_plus;
   logic                    in_win;
   logic                    out_free;
   logic                    req_fire;
   logic                    good;
   logic                    hit;
   logic                    store;
   logic                    deliv_fire;
   logic                    drain_fire;
   logic                    adv;

   srr_store_cmd_type       cmd;
   logic [PAYLOAD_BITS-1:0] rd_data;
   logic                    chk_valid;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = WIN_BITS'(1);
      end else if (win_ff > WIN_BITS'(WINDOW_MAX)) begin
         win_eff = WIN_BITS'(WINDOW_MAX);
      end else begin
         win_eff = win_ff;
      end
   end

   assign offset     = req_chan.seq_num - exp_ff;
   assign in_win     = offset < SEQ_BITS'(win_eff);
   assign exp_plus   = exp_ff + SEQ_BITS'(1);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign good       = req_fire && !req_chan.corrupted;
   assign hit        = good && in_win && (offset == '0);
   assign store      = good && in_win && (offset != '0);
   assign deliv_fire = (state_ff == ST_DELIV) && out_free;
   assign drain_fire = (state_ff == ST_DRAIN) && out_free;
   assign adv        = deliv_fire || drain_fire;

   // read ahead one slot when advancing so drain data is ready next cycle
   always_comb begin
      cmd.wr_en   = store;
      cmd.wr_idx  = req_chan.seq_num[IDX_BITS-1:0];
      cmd.wr_data = req_chan.payload_word;
      cmd.clr_en  = adv;
      cmd.clr_idx = exp_ff[IDX_BITS-1:0];
      cmd.rd_idx  = adv ? exp_plus[IDX_BITS-1:0] : exp_ff[IDX_BITS-1:0];
      cmd.chk_idx = exp_plus[IDX_BITS-1:0];
   end

   srr_slot_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_data   (rd_data),
      .chk_valid (chk_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= SEQ_START;
         win_ff       <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         if (adv) begin
            exp_ff <= exp_plus;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (hit) begin
                  state_ff <= ST_DELIV;
               end
            end
            ST_DELIV, ST_DRAIN: begin
               if (out_free) begin
                  state_ff <= chk_valid ? ST_DRAIN : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (good || adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (hit) begin
            pay_ff <= req_chan.payload_word;
         end

         if (good) begin
            rsp_kind_ff <= KIND_ACK;
            rsp_ack_ff  <= req_chan.seq_num;
            rsp_pay_ff  <= '0;
            rsp_last_ff <= !hit;
         end else if (adv) begin
            rsp_kind_ff <= KIND_DELIVER;
            rsp_ack_ff  <= exp_ff;
            rsp_pay_ff  <= deliv_fire ? pay_ff : rd_data;
            rsp_last_ff <= !chk_valid;
         end
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.kind              = rsp_kind_ff;
   assign rsp_chan.ack_num           = rsp_ack_ff;
   assign rsp_chan.delivered_payload = rsp_pay_ff;
   assign rsp_chan.last              = rsp_last_ff;

   a_ack_follows: assert property (@(posedge clock) disable iff (reset)
      good |=> rsp_chan.valid && (rsp_kind_ff == KIND_ACK))
      else $error("accepted packet not acknowledged");

   a_hit_not_last: assert property (@(posedge clock) disable iff (reset)
      hit |=> (state_ff == ST_DELIV) && !rsp_last_ff)
      else $error("in-order packet ack marked last");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      adv && !chk_valid |=> (state_ff == ST_IDLE) && rsp_last_ff)
      else $error("drain did not end on an empty slot");

endmodule

`default_nettype wire

// ===== rtl/srr_slot_store.sv =====
// srr_slot_store: reorder slots, a payload memory with registered read and
// a flop map of slot valid bits cleared at reset. Depends on srr_pkg.
`default_nettype none

module srr_slot_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire srr_pkg::srr_store_cmd_type      cmd,
   output logic [srr_pkg::PAYLOAD_BITS-1:0]     rd_data,
   output logic                                 chk_valid
);
   import srr_pkg::*;

   logic [PAYLOAD_BITS-1:0] payload_mem_ff [WINDOW_MAX];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic [WINDOW_MAX-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         payload_mem_ff[cmd.wr_idx] <= cmd.wr_data;
      end
      rd_data_ff <= payload_mem_ff[cmd.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.clr_en) begin
            valid_ff[cmd.clr_idx] <= 1'b0;
         end
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_idx] <= 1'b1;
         end
      end
   end

   assign rd_data   = rd_data_ff;
   assign chk_valid = valid_ff[cmd.chk_idx];

   // storing only happens from idle, draining only outside idle
   a_no_wr_clr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.clr_en))
      else $error("slot write and clear in the same cycle");

   // a stored slot reads as valid on the next cycle
   a_wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> valid_ff[$past(cmd.wr_idx)])
      else $error("stored slot not marked valid");

   a_clr_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |=> !valid_ff[$past(cmd.clr_idx)])
      else $error("drained slot still valid");

endmodule

`default_nettype wire
